[sv/bibr_pkg.sv]
// ---------------------------------------------------------------------------
// bibr_pkg
// shared types and constants of the brownian increment bridge refine unit
// ---------------------------------------------------------------------------
package bibr_pkg;

  localparam int unsigned DimDefault = 2;
  localparam logic [15:0] EpsReset  = 16'd1;
  localparam int unsigned QueueDepth = 2;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0] step_h;
    logic        bisect;
    logic [15:0] sample_z;
  } item_t;

endpackage

[sv/bibr_front.sv]
// ---------------------------------------------------------------------------
// bibr_front
// input stage: accepts items into a short queue toward the back end
// ---------------------------------------------------------------------------
module bibr_front
  import bibr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output item_t q_item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             push, pop;

  assign in_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

[sv/bibr_sqrt.sv]
// ---------------------------------------------------------------------------
// bibr_sqrt
// iterative integer square root of a 50-bit radicand, one result bit a cycle
// ---------------------------------------------------------------------------
module bibr_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] rad_i,
  output logic        done_o,
  output logic [24:0] root_o
);

  logic [49:0] rem_q, rem_d;
  logic [24:0] root_q, root_d;
  logic [49:0] rad_q, rad_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [51:0] trial, shifted;

  assign done_o = done_q;
  assign root_o = root_q;

  always_comb begin
    rem_d   = rem_q;
    root_d  = root_q;
    rad_d   = rad_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, rad_q[49:48]};
    trial   = {25'd0, root_q, 2'b01};
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      rad_d  = rad_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[47:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = 50'(shifted - trial);
        root_d = {root_q[23:0], 1'b1};
      end else begin
        rem_d  = 50'(shifted);
        root_d = {root_q[23:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd24) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

[sv/bibr_back.sv]
// ---------------------------------------------------------------------------
// bibr_back
// back end: square root, scaled sample, bridge state and result register
// ---------------------------------------------------------------------------
module bibr_back
  import bibr_pkg::*;
#(
  parameter int unsigned Dim = DimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] eps_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_inc_o,
  output logic        out_last_o,
  output logic        out_terr_o,
  output logic [31:0] out_time_o
);

  localparam int unsigned Elems = Dim * Dim;
  localparam int unsigned KW    = (Elems > 1) ? $clog2(Elems) : 1;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRoot = 4'b0010,
    StMul  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] last_inc_q [Elems];
  logic [31:0] rem_q      [Elems];
  logic [Elems-1:0] vld_q;
  logic [31:0] path_q, bend_q;
  logic        refined_q;
  logic [KW-1:0] k_q;

  item_t       it_q;
  logic        terr_q;
  logic [49:0] rad;
  logic        sq_start, sq_done;
  logic [24:0] root;
  logic signed [41:0] prod_q;
  logic signed [31:0] old_rd_q, rem_rd_q;

  logic [31:0] inc_q, time_q;
  logic        last_q, terr_out_q;

  logic [KW-1:0] k_sel;
  logic          last_el;
  logic signed [33:0] gap;
  logic signed [31:0] old_v, rem_v;

  assign k_sel   = k_q;
  assign last_el = (k_q == KW'(Elems - 1));
  assign old_v   = vld_q[k_sel] ? old_rd_q : 32'sd0;
  assign rem_v   = vld_q[k_sel] ? rem_rd_q : 32'sd0;
  assign gap     = $signed({2'b00, path_q}) + $signed({2'b00, q_item_i.step_h})
                 - $signed({2'b00, bend_q}) + $signed({18'd0, eps_i});

  always_comb begin
    rad = {2'b00, q_item_i.step_h, 16'd0};
    if (q_item_i.bisect) rad = {3'b000, q_item_i.step_h, 15'd0};
    else if (refined_q) rad = gap[33] ? 50'd0 : {gap[33:0], 16'd0};
  end

  assign q_pop_o  = (state_q == StIdle) && q_valid_i;
  assign sq_start = q_pop_o;

  bibr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (rad),
    .done_o (sq_done),
    .root_o (root)
  );

  // rounded scaled sample, exact sums and saturation
  logic signed [41:0] scaled;
  logic signed [35:0] sum, rsum;
  logic signed [31:0] inc_new, rem_new;
  logic [32:0]        t_up;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF)       return 32'sh7FFFFFFF;
    else if (v < -36'sh080000000) return 32'sh80000000;
    else                          return v[31:0];
  endfunction

  always_comb begin
    scaled  = (prod_q + 42'sd2048) >>> 12;
    if (it_q.bisect)
      sum = 36'(old_v >>> 1) + 36'(scaled);
    else if (refined_q)
      sum = 36'(rem_v) + 36'(scaled);
    else
      sum = 36'(scaled);
    inc_new = sat32(sum);
    rsum = 36'(old_v) - 36'(inc_new);
    if (refined_q) rsum = rsum + 36'(rem_v);
    rem_new = sat32(rsum);
    t_up = {1'b0, path_q} + {1'b0, it_q.step_h};
  end

  assign out_valid_o = (state_q == StOut);
  assign out_inc_o   = inc_q;
  assign out_last_o  = last_q;
  assign out_terr_o  = terr_out_q;
  assign out_time_o  = time_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (q_valid_i) state_d = StRoot;
      StRoot: if (sq_done)   state_d = StMul;
      StMul:                 state_d = StOut;
      StOut:  if (out_ready_i) state_d = StIdle;
      default:               state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_q   <= q_item_i;
      terr_q <= !q_item_i.bisect && refined_q && gap[33];
    end
    // element index is stable while the root runs
    if (state_q == StRoot) begin
      old_rd_q <= last_inc_q[k_sel];
      rem_rd_q <= rem_q[k_sel];
    end
    if (state_q == StRoot && sq_done)
      prod_q <= $signed({17'd0, root}) * $signed(it_q.sample_z);
    if (state_q == StMul) begin
      last_inc_q[k_sel] <= inc_new;
      if (it_q.bisect) rem_q[k_sel] <= rem_new;
      else if (!vld_q[k_sel]) rem_q[k_sel] <= '0;
      inc_q      <= inc_new;
      last_q     <= last_el;
      terr_out_q <= terr_q;
      time_q     <= path_q;
      if (last_el) begin
        if (it_q.bisect)
          time_q <= (path_q >= it_q.step_h) ? path_q - it_q.step_h : 32'd0;
        else
          time_q <= t_up[32] ? 32'hFFFFFFFF : t_up[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      vld_q     <= '0;
      path_q    <= '0;
      bend_q    <= '0;
      refined_q <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StMul) begin
        vld_q[k_sel] <= 1'b1;
        k_q <= last_el ? '0 : k_q + 1'b1;
        if (last_el) begin
          if (it_q.bisect) begin
            if (!refined_q) begin
              bend_q    <= path_q;
              refined_q <= 1'b1;
            end
            path_q <= (path_q >= it_q.step_h) ? path_q - it_q.step_h : 32'd0;
          end else begin
            refined_q <= 1'b0;
            path_q    <= t_up[32] ? 32'hFFFFFFFF : t_up[31:0];
          end
        end
      end
    end
  end

endmodule

[sv/brownian_increment_bridge_refine_unit.sv]
// ---------------------------------------------------------------------------
// brownian_increment_bridge_refine_unit
// brownian increments with bridge refinement for a Dim x Dim matrix
// ---------------------------------------------------------------------------
// s_axis carries one normal sample per item, row-major over the matrix,
// with its time step and half-step flag. m_axis returns one increment per
// item, with last-of-matrix, the time error flag and the path time.
// time_epsilon_we_i writes the refined-gap slack; write only when idle.
// A two-entry queue takes items while the back end works. The back end
// runs one item at a time: it issues the item, runs the bit-serial square
// root and registers the product, then scales, sums and writes back, then
// holds the result for the handshake. It pops no new item from the queue
// until the result has been taken.
// Reset clears path time, refinement and counters; stored increments and
// remainders read as zero until written. While m_axis_tready_i is low the
// result holds and the queue fills, then s_axis_tready_o drops.
// ---------------------------------------------------------------------------
module brownian_increment_bridge_refine_unit
  import bibr_pkg::*;
#(
  parameter int unsigned Dim = DimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        time_epsilon_we_i,
  input  logic [15:0] time_epsilon_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // step_h[31:0], sample_z[47:32]
  input  logic        s_axis_tuser_i,  // bisect
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // increment_value[31:0], time_now[63:32]
  output logic        m_axis_tlast_o,  // last_of_matrix
  output logic        m_axis_tuser_o   // time_error
);

  logic [15:0] eps_q;
  item_t in_item, q_item;
  logic  q_valid, q_pop;
  logic [31:0] inc, tnow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= EpsReset;
    else if (time_epsilon_we_i) eps_q <= time_epsilon_i;
  end

  assign in_item.step_h    = s_axis_tdata_i[31:0];
  assign in_item.sample_z  = s_axis_tdata_i[47:32];
  assign in_item.bisect    = s_axis_tuser_i;

  bibr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .in_item_i (in_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  bibr_back #(.Dim(Dim)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .eps_i      (eps_q),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_inc_o  (inc),
    .out_last_o (m_axis_tlast_o),
    .out_terr_o (m_axis_tuser_o),
    .out_time_o (tnow)
  );

  assign m_axis_tdata_o = {tnow, inc};

endmodule

[tb/sv/bibr_checker.sv]
// ---------------------------------------------------------------------------
// bibr_checker
// watches both stream channels, predicts every increment and compares it
// ---------------------------------------------------------------------------
module bibr_checker
  import bibr_pkg::*;
#(
  parameter int unsigned Dim = DimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        time_epsilon_we_i,
  input  logic [15:0] time_epsilon_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [63:0] m_axis_tdata_o,
  input  logic        m_axis_tlast_o,
  input  logic        m_axis_tuser_o,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned Elems = Dim * Dim;

  typedef struct packed {
    logic [31:0] increment;
    logic        last_of_matrix;
    logic        time_error;
    logic [31:0] time_now;
  } increment_t;

  increment_t       expected_increments[$];
  logic signed [63:0] last_inc   [Elems];
  logic signed [63:0] remainder  [Elems];
  logic [63:0]      path_time;
  logic [63:0]      bridge_end;
  logic             refined;
  int unsigned      elem_idx;
  logic [15:0]      epsilon;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factor * z in Q.28, rounded to Q16.16 by floor((p + 2048) / 4096)
  function automatic logic signed [63:0] scale_sample(input logic [63:0] f,
                                                      input logic signed [15:0] z);
    logic signed [63:0] p;
    p = $signed(f) * 64'(z) + 64'sd2048;
    return p >>> 12;
  endfunction

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_increment(input logic [31:0] h, input logic half,
                                   input logic signed [15:0] z);
    logic signed [63:0] gap;
    logic signed [63:0] inc;
    logic signed [63:0] old;
    logic [63:0]        f;
    logic               last;
    logic               terr;
    increment_t         e;
    last = (elem_idx == Elems - 1);
    terr = 1'b0;
    if (!half) begin
      if (refined) begin
        gap = $signed(path_time) + $signed({32'd0, h}) - $signed(bridge_end)
              + $signed({48'd0, epsilon});
        if (gap < 0) begin
          terr = 1'b1;
          gap = 0;
        end
        f = int_sqrt(gap << 16);
        inc = clip32(remainder[elem_idx] + scale_sample(f, z));
      end else begin
        f = int_sqrt({32'd0, h} << 16);
        inc = clip32(scale_sample(f, z));
      end
      last_inc[elem_idx] = inc;
      if (last) begin
        refined = 1'b0;
        path_time = path_time + h;
        if (path_time > 64'hFFFF_FFFF) path_time = 64'hFFFF_FFFF;
      end
    end else begin
      old = last_inc[elem_idx];
      f = int_sqrt({32'd0, h} << 15);
      inc = clip32((old >>> 1) + scale_sample(f, z));
      last_inc[elem_idx] = inc;
      if (refined) remainder[elem_idx] = clip32(remainder[elem_idx] + (old - inc));
      else remainder[elem_idx] = clip32(old - inc);
      if (last) begin
        if (!refined) begin
          bridge_end = path_time;
          refined = 1'b1;
        end
        path_time = (path_time >= h) ? path_time - h : 64'd0;
      end
    end
    elem_idx = last ? 0 : elem_idx + 1;
    e.increment      = inc[31:0];
    e.last_of_matrix = last;
    e.time_error     = terr;
    e.time_now       = path_time[31:0];
    expected_increments = {expected_increments, e};
  endtask

  initial begin
    fail_count_o = 0;
    epsilon = EpsReset;
    path_time = 0;
    bridge_end = 0;
    refined = 1'b0;
    elem_idx = 0;
    for (int i = 0; i < Elems; i++) begin
      last_inc[i] = 0;
      remainder[i] = 0;
    end
  end

  assign pending_o = expected_increments.size();

  always @(posedge clk_i) begin
    increment_t got;
    increment_t want;
    if (rst_ni) begin
      if (time_epsilon_we_i) epsilon = time_epsilon_i;
      // result first: an item accepted now cannot be the one leaving now
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.increment      = m_axis_tdata_o[31:0];
        got.time_now       = m_axis_tdata_o[63:32];
        got.last_of_matrix = m_axis_tlast_o;
        got.time_error     = m_axis_tuser_o;
        if (expected_increments.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected item: %p", got);
        end else begin
          want = expected_increments.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        predict_increment(s_axis_tdata_i[31:0], s_axis_tuser_i, s_axis_tdata_i[47:32]);
    end
  end

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// drives samples and time steps through the increment unit under several
// idling patterns and epsilon settings; the checker predicts and compares
// ---------------------------------------------------------------------------
module testbench
  import bibr_pkg::*;
;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        time_epsilon_we_i = 1'b0;
  logic [15:0] time_epsilon_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;  // step_h[31:0], sample_z[47:32]
  logic        s_axis_tuser_i = 1'b0;  // bisect
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;  // increment_value[31:0], time_now[63:32]
  logic        m_axis_tlast_o;  // last_of_matrix
  logic        m_axis_tuser_o;  // time_error
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  brownian_increment_bridge_refine_unit #(.Dim(DimDefault)) dut (.*);

  bibr_checker #(.Dim(DimDefault)) u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays high between back-to-back items, drops only while idling
  task automatic send_item(input logic [31:0] h, input logic half, input logic [15:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, h};
    s_axis_tuser_i  <= half;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_and_write_epsilon(input logic [15:0] eps);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    time_epsilon_we_i <= 1'b1;
    time_epsilon_i    <= eps;
    @(negedge clk_i);
    time_epsilon_we_i <= 1'b0;
  endtask

  // random step: mostly small sizes, a few extremes
  function automatic logic [31:0] pick_step();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  // one matrix; refine chains bisect first then step forward
  task automatic send_matrix(input logic half);
    for (int i = 0; i < DimDefault * DimDefault; i++)
      send_item(pick_step(), ($urandom_range(15) == 0) ? ~half : half, 16'($urandom()));
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: extremes, both modes, negative refined gap, time saturation
    send_item(32'hFFFF_FFFF, 1'b0, 16'h7FFF);
    send_item(32'hFFFF_FFFF, 1'b0, 16'h8000);
    send_item(32'h0001_0000, 1'b0, 16'h1000);
    send_item(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
    send_item(32'h0000_0000, 1'b1, 16'h7FFF);
    send_item(32'hFFFF_FFFF, 1'b1, 16'h8000);
    send_item(32'h0001_0000, 1'b1, 16'h0000);
    send_item(32'h0002_0000, 1'b1, 16'h0800);
    send_item(32'h0000_0001, 1'b1, 16'h8000);
    send_item(32'h0000_0001, 1'b1, 16'h7FFF);
    send_item(32'h0000_0000, 1'b1, 16'h1234);
    send_item(32'h0000_0000, 1'b1, 16'hF000);
    send_item(32'h0000_0000, 1'b0, 16'h7FFF);
    send_item(32'h0000_0000, 1'b0, 16'h8000);
    send_item(32'h0000_0000, 1'b0, 16'h0001);
    send_item(32'h8000_0000, 1'b0, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_item(32'hFFFF_FFFF, 1'b0, 16'h4000);
    drain_and_write_epsilon(16'hFFFF);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (ph == 0) hold_off = 400;
      for (int m = 0; m < 26; m++) begin
        if ($urandom_range(3) == 0) send_matrix(1'($urandom_range(1)));
        else begin
          repeat ($urandom_range(1, 2)) send_matrix(1'b1);
          send_matrix(1'b0);
        end
      end
      drain_and_write_epsilon((ph == 0) ? 16'h0000 : (ph == 1) ? 16'd1 : 16'($urandom()));
    end
    recv_stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/bibr_pkg.sv
sv/bibr_front.sv
sv/bibr_sqrt.sv
sv/bibr_back.sv
sv/brownian_increment_bridge_refine_unit.sv
tb/sv/bibr_checker.sv
tb/sv/testbench.sv
